FILE: rtl/mwcd_pkg.sv
`timescale 1ns / 1ps
// mwcd_pkg: shared types, constants and the entropy step table for the
// moving window class diversity block. No dependencies.
package mwcd_pkg;

  localparam int WIN_MAX     = 15;
  localparam int MAX_COLS    = 1024;
  localparam int NUM_CLASSES = 256;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROWSEL_W    = $clog2(WIN_MAX + 1);
  localparam int LS_DEPTH    = (WIN_MAX + 1) * MAX_COLS;
  localparam int BIN_W       = $clog2(NUM_CLASSES);

  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  localparam logic [2:0] REG_METRIC  = 3'd0;
  localparam logic [2:0] REG_SIDE    = 3'd1;
  localparam logic [2:0] REG_COLS    = 3'd2;
  localparam logic [2:0] REG_ROWS    = 3'd3;
  localparam logic [2:0] REG_ND_EN   = 3'd4;
  localparam logic [2:0] REG_ND_CODE = 3'd5;

  localparam logic [1:0] MODE_SHANNON  = 2'd0;
  localparam logic [1:0] MODE_SIMPSON  = 2'd1;
  localparam logic [1:0] MODE_RICHNESS = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] class_code;
  } in_item_t;

  typedef struct packed {
    logic [24:0] metric_value;
    logic        is_nodata;
    logic        is_last;
  } out_item_t;

  typedef logic [255:0][39:0] gtab_t;

  // log2 with 32 fraction bits, truncated
  function automatic logic [63:0] log2_fixed(input logic [31:0] c);
    logic [31:0] k;
    logic [63:0] x;
    logic [31:0] frac;
    k = 32'd0;
    frac = 32'd0;
    for (int i = 0; i < 31; i++) begin
      if ((c >> (i + 1)) != 32'd0) k = 32'(i + 1);
    end
    x = 64'(c) << (31 - k);
    for (int i = 1; i <= 32; i++) begin
      x = (x * x) >> 31;
      if (x >= (64'd1 << 32)) begin
        x = x >> 1;
        frac[32 - i] = 1'b1;
      end
    end
    return {k, frac};
  endfunction

  // step of c*log2(c) from c-1 to c
  function automatic gtab_t build_gtab();
    gtab_t t;
    logic [63:0] prev;
    logic [63:0] cur;
    t = '0;
    prev = 64'd0;
    for (int c = 1; c < 256; c++) begin
      cur = 64'(c) * log2_fixed(32'(c));
      t[c] = 40'(cur - prev);
      prev = cur;
    end
    return t;
  endfunction

  localparam gtab_t GTAB = build_gtab();

endpackage

FILE: rtl/moving_window_class_diversity.sv
`timescale 1ns / 1ps
// moving_window_class_diversity: top level, sequencer, line store and histogram.
// Depends on mwcd_pkg, mwcd_ram and mwcd_div.
//
// A pixel item that produces no result is taken while the sequencer stays
// idle. An item that releases a result reads the centre in S_CRD and S_CCHK,
// then walks the window cell by cell through the line store and histogram
// RAMs: S_WRD, S_HRD and S_UPD for a valid cell, S_WRD and S_HRD for a nodata
// cell, then the shared bit-serial divider for Shannon or Simpson and a split
// multiply and rounding for Shannon. A nodata centre skips the walk. The
// histogram is cleared at the start of each window through per-bin valid bits,
// so no clearing pass is needed. Input is not ready while a result is worked on;
// a finished result waits in the output register while the next item is taken.
// Register writes are taken only while idle and win over a pending input item.
module moving_window_class_diversity
  import mwcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_CCHK = 4'd2;
  localparam logic [3:0] S_WRD  = 4'd3;
  localparam logic [3:0] S_HRD  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_CALC = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_MUL1 = 4'd8;
  localparam logic [3:0] S_MUL2 = 4'd9;
  localparam logic [3:0] S_RND  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state;

  logic [1:0]  metric_mode;
  logic [3:0]  window_side;
  logic [10:0] raster_cols;
  logic [15:0] raster_rows;
  logic        nodata_enable;
  logic [7:0]  nodata_code;

  logic [10:0] cols_eff;
  logic [15:0] rows_eff;
  logic [2:0]  half;
  logic [13:0] delay;

  logic [15:0]      in_row;
  logic [COL_W-1:0] in_col;
  logic [15:0]      out_row;
  logic [COL_W-1:0] out_col;
  logic [13:0]      pend;

  logic [15:0]      wr, rs, re;
  logic [COL_W-1:0] wc, cs, ce;
  logic [BIN_W-1:0] bin;
  logic [NUM_CLASSES-1:0] hvalid;

  logic [7:0]  n;
  logic [7:0]  distinct;
  logic [15:0] nn, sq;
  logic [43:0] s, fsum;
  logic [59:0] acc;
  logic [24:0] val;
  logic        nodata;

  logic        in_acc, in_done, in_col_last, last_cell, is_last, fin_go;
  logic [13:0] pend_inc;
  logic [7:0]  st_rdata, h_rdata, cold, cnew;
  logic        st_we;
  logic        div_start, div_done;
  logic [47:0] div_dividend, div_quot;
  logic [15:0] div_divisor;
  logic [17:0] mul_a;
  logic [41:0] prod;
  logic [59:0] rnd_sum;

  function automatic logic missing(input logic [7:0] code, input logic en,
                                   input logic [7:0] ndc);
    return en && (code == ndc);
  endfunction

  assign cols_eff = (raster_cols == 11'd0) ? 11'd1 :
                    (raster_cols > 11'(MAX_COLS)) ? 11'(MAX_COLS) : raster_cols;
  assign rows_eff = (raster_rows == 16'd0) ? 16'd1 : raster_rows;
  assign half     = (window_side < 4'd3) ? 3'd1 : window_side[3:1];
  assign delay    = 14'(half) * 14'(cols_eff) + 14'(half);

  assign in_ready    = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready   = (state == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign in_done     = in_row >= rows_eff;
  assign in_col_last = (11'(in_col) + 11'd1) >= cols_eff;
  assign pend_inc    = pend + 14'd1;
  assign st_we       = in_acc && (in_data.req_type == REQ_PIXEL) && !in_done;
  assign last_cell   = (wc == ce) && (wr == re);
  assign is_last     = (out_row == rows_eff - 16'd1) && (11'(out_col) == cols_eff - 11'd1);
  assign fin_go      = !out_valid || out_ready;

  assign cold = hvalid[bin] ? h_rdata : 8'd0;
  assign cnew = cold + 8'd1;

  mwcd_ram #(.WIDTH(8), .DEPTH(LS_DEPTH)) u_line (
    .clk  (clk),
    .we   (st_we),
    .waddr({in_row[ROWSEL_W-1:0], in_col}),
    .wdata(in_data.class_code),
    .raddr({wr[ROWSEL_W-1:0], wc}),
    .rdata(st_rdata)
  );

  mwcd_ram #(.WIDTH(8), .DEPTH(NUM_CLASSES)) u_hist (
    .clk  (clk),
    .we   (state == S_UPD),
    .waddr(bin),
    .wdata(cnew),
    .raddr(st_rdata),
    .rdata(h_rdata)
  );

  assign div_start    = (state == S_CALC) && (n != 8'd0) && !metric_mode[1];
  assign div_dividend = (metric_mode == MODE_SHANNON) ?
                        48'((fsum >= s) ? (fsum - s) : 44'd0) :
                        48'({16'(nn - sq), 16'h0}) + 48'(nn[15:1]);
  assign div_divisor  = (metric_mode == MODE_SHANNON) ? 16'(n) : nn;

  mwcd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quot)
  );

  assign mul_a   = (state == S_MUL1) ? div_quot[17:0] : {1'b0, div_quot[34:18]};
  assign prod    = mul_a * LN2_Q24;
  assign rnd_sum = acc + (60'd1 << 39);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      metric_mode   <= 2'd0;
      window_side   <= 4'd3;
      raster_cols   <= 11'd1024;
      raster_rows   <= 16'd1;
      nodata_enable <= 1'b0;
      nodata_code   <= 8'd0;
      in_row        <= '0;
      in_col        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      pend          <= '0;
      hvalid        <= '0;
    end else begin
      if (out_ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if ((in_data.req_type == REQ_FLUSH && in_done) ||
                (in_data.req_type == REQ_PIXEL && !in_done && pend_inc > delay)) begin
              state    <= S_CRD;
              wr       <= out_row;
              wc       <= out_col;
              rs       <= (out_row > 16'(half)) ? out_row - 16'(half) : 16'd0;
              re       <= ((17'(out_row) + 17'(half)) < 17'(rows_eff)) ?
                          out_row + 16'(half) : rows_eff - 16'd1;
              cs       <= (out_col > COL_W'(half)) ? out_col - COL_W'(half) : '0;
              ce       <= ((11'(out_col) + 11'(half)) < cols_eff) ?
                          out_col + COL_W'(half) : COL_W'(cols_eff - 11'd1);
              n        <= 8'd0;
              distinct <= 8'd0;
              nn       <= 16'd0;
              sq       <= 16'd0;
              s        <= 44'd0;
              fsum     <= 44'd0;
              nodata   <= 1'b0;
              val      <= 25'd0;
            end
            if (in_data.req_type == REQ_PIXEL && !in_done) begin
              pend <= pend_inc;
              if (in_col_last) begin
                in_col <= '0;
                in_row <= in_row + 16'd1;
              end else begin
                in_col <= in_col + COL_W'(1);
              end
            end
          end
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          if (missing(st_rdata, nodata_enable, nodata_code)) begin
            nodata <= 1'b1;
            state  <= S_FIN;
          end else begin
            wr     <= rs;
            wc     <= cs;
            hvalid <= '0;
            state  <= S_WRD;
          end
        end
        S_WRD: state <= S_HRD;
        S_HRD: begin
          bin <= st_rdata;
          if (!missing(st_rdata, nodata_enable, nodata_code)) begin
            state <= S_UPD;
          end else if (last_cell) begin
            state <= S_CALC;
          end else begin
            state <= S_WRD;
            if (wc == ce) begin
              wr <= wr + 16'd1;
              wc <= cs;
            end else begin
              wc <= wc + COL_W'(1);
            end
          end
        end
        S_UPD: begin
          hvalid[bin] <= 1'b1;
          n        <= n + 8'd1;
          distinct <= distinct + ((cold == 8'd0) ? 8'd1 : 8'd0);
          s        <= s + 44'(GTAB[cnew]);
          fsum     <= fsum + 44'(GTAB[n + 8'd1]);
          sq       <= sq + {7'd0, cold, 1'b1};
          nn       <= nn + {7'd0, n, 1'b1};
          if (last_cell) begin
            state <= S_CALC;
          end else begin
            state <= S_WRD;
            if (wc == ce) begin
              wr <= wr + 16'd1;
              wc <= cs;
            end else begin
              wc <= wc + COL_W'(1);
            end
          end
        end
        S_CALC: begin
          if (n == 8'd0) begin
            nodata <= 1'b1;
            state  <= S_FIN;
          end else if (metric_mode[1]) begin
            val   <= 25'({distinct, 16'h0});
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (metric_mode == MODE_SIMPSON) begin
              val   <= 25'(div_quot);
              state <= S_FIN;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          acc   <= 60'(prod);
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc + (60'(prod) << 18);
          state <= S_RND;
        end
        S_RND: begin
          val   <= 25'(rnd_sum[59:40]);
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            out_data  <= '{metric_value: val, is_nodata: nodata, is_last: is_last};
            state     <= S_IDLE;
            if (is_last) begin
              in_row  <= '0;
              in_col  <= '0;
              out_row <= '0;
              out_col <= '0;
              pend    <= '0;
            end else begin
              pend <= pend - 14'd1;
              if ((11'(out_col) + 11'd1) >= cols_eff) begin
                out_col <= '0;
                out_row <= out_row + 16'd1;
              end else begin
                out_col <= out_col + COL_W'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_METRIC:  metric_mode   <= cfg_data[1:0];
          REG_SIDE:    window_side   <= cfg_data[3:0];
          REG_COLS:    raster_cols   <= cfg_data[10:0];
          REG_ROWS:    raster_rows   <= cfg_data[15:0];
          REG_ND_EN:   nodata_enable <= cfg_data[0];
          REG_ND_CODE: nodata_code   <= cfg_data[7:0];
          default: ;
        endcase
        if (cfg_index == REG_SIDE || cfg_index == REG_COLS || cfg_index == REG_ROWS) begin
          in_row  <= '0;
          in_col  <= '0;
          out_row <= '0;
          out_col <= '0;
          pend    <= '0;
        end
      end
    end
  end

endmodule

FILE: rtl/mwcd_ram.sv
`timescale 1ns / 1ps
// mwcd_ram: generic single write, single read RAM with registered read.
// No dependencies.
module mwcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mwcd_div.sv
`timescale 1ns / 1ps
// mwcd_div: restoring divider, one quotient bit per cycle, 48 by 16 bits.
// No dependencies.
module mwcd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic        run;
  logic [16:0] r2;
  logic        ge;

  assign r2 = {rem, quotient[47]};
  assign ge = r2 >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= 6'd47;
        rem      <= 16'd0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        rem      <= ge ? 16'(r2 - {1'b0, dvs}) : r2[15:0];
        quotient <= {quotient[46:0], ge};
        cnt      <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/mwcd_chk.sv
`timescale 1ns / 1ps
// mwcd_chk: port-level checks on the moving window class diversity block,
// bound to the top level. Depends on mwcd_pkg.
module mwcd_chk
  import mwcd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_data
);

  // a waiting result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // nodata results carry a zero value
  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_nodata |-> out_data.metric_value == 25'd0)
    else $error("nodata result with nonzero value");

  // a result never appears the cycle after the item that caused it
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

  // values stay within the output range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.metric_value <= 25'd16777216)
    else $error("metric value out of range");

endmodule

bind moving_window_class_diversity mwcd_chk u_mwcd_chk (.*);
